FILE: design/deadline_timer_queue_defines.svh
// assertion macros used by the deadline timer queue datapath
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define DTQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/dtq_pkg.sv
// types and constants of the deadline timer queue
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 48;
   localparam int TAG_BITS    = 8;
   localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS  = TIME_BITS + TAG_BITS;

   localparam logic [TIME_BITS-1:0] TIME_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      FUNC_SCHED_ABS = 2'd0,
      FUNC_SCHED_REL = 2'd1,
      FUNC_TICK      = 2'd2,
      FUNC_CLEAR     = 2'd3
   } func_type;

   localparam logic RESULT_EXPIRED  = 1'b0;
   localparam logic RESULT_REJECTED = 1'b1;

   typedef struct packed {
      logic take;
      logic sched;
      logic rel;
      logic tick;
      logic clear;
      logic scan_init;
      logic scan_step;
      logic shift_init;
      logic shift_step;
      logic remove;
      logic out_fire;
      logic out_reject;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic walk_done;
      logic due_any;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: design/dtq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/dtq_datapath.sv
// timer store, running time, earliest-deadline scan and result register
`timescale 1ns / 1ps
`default_nettype none

`include "deadline_timer_queue_defines.svh"

module dtq_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [dtq_pkg::TAG_BITS-1:0]  req_entry_tag,
   input  wire logic [dtq_pkg::TIME_BITS-1:0] req_time_value,
   input  wire dtq_pkg::cmd_type             cmd,
   output dtq_pkg::stat_type                 stat,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_result_kind,
   output logic [dtq_pkg::TAG_BITS-1:0]      rsp_fired_tag,
   output logic                              rsp_last_of_run
);

   logic [dtq_pkg::TIME_BITS-1:0] time_ff, time_in;
   logic [dtq_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic [dtq_pkg::TAG_BITS-1:0]  tag_ff, tag_in;
   logic [dtq_pkg::CNT_BITS-1:0]  ptr_ff, ptr_in;
   logic                          vld_ff, vld_in;
   logic [dtq_pkg::CNT_BITS-1:0]  idx_ff, idx_in;
   logic [dtq_pkg::CNT_BITS-1:0]  due_ff, due_in;
   logic                          best_vld_ff, best_vld_in;
   logic [dtq_pkg::TIME_BITS-1:0] best_key_ff, best_key_in;
   logic [dtq_pkg::CNT_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [dtq_pkg::TAG_BITS-1:0]  best_tag_ff, best_tag_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [dtq_pkg::TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                            issue;
   logic                            out_free;
   logic [dtq_pkg::TIME_BITS-1:0]   deadline;
   logic                            wr_en;
   logic [dtq_pkg::CNT_BITS-1:0]    wr_idx;
   logic [dtq_pkg::ADDR_BITS-1:0]   wr_addr;
   logic [dtq_pkg::ENTRY_BITS-1:0]  wr_data;
   logic [dtq_pkg::ENTRY_BITS-1:0]  rd_data;
   logic [dtq_pkg::TIME_BITS-1:0]   rd_deadline;
   logic [dtq_pkg::TAG_BITS-1:0]    rd_tag;
   logic [dtq_pkg::TIME_BITS-1:0]   delta;
   logic [dtq_pkg::TIME_BITS-1:0]   key;
   logic                            due;
   logic                            better;

   dtq_ram #(
      .WIDTH (dtq_pkg::ENTRY_BITS),
      .DEPTH (dtq_pkg::QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[dtq_pkg::ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign issue    = (cmd.scan_step | cmd.shift_step) && (ptr_ff < count_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign deadline = cmd.rel ? time_ff + req_time_value : req_time_value;

   // shift writes each entry one place down, behind its read
   assign wr_en   = cmd.sched || (cmd.shift_step && vld_ff);
   assign wr_idx  = idx_ff - dtq_pkg::CNT_BITS'(1);
   assign wr_addr = cmd.sched ? count_ff[dtq_pkg::ADDR_BITS-1:0]
                              : wr_idx[dtq_pkg::ADDR_BITS-1:0];
   assign wr_data = cmd.sched ? {req_entry_tag, deadline} : rd_data;

   assign rd_deadline = rd_data[dtq_pkg::TIME_BITS-1:0];
   assign rd_tag      = rd_data[dtq_pkg::ENTRY_BITS-1:dtq_pkg::TIME_BITS];

   // signed distance to now, biased so unsigned compare gives signed order
   assign delta  = rd_deadline - time_ff;
   assign key    = delta ^ dtq_pkg::TIME_SIGN;
   assign due    = delta[dtq_pkg::TIME_BITS-1] || (delta == '0);
   assign better = !best_vld_ff || (key < best_key_ff);

   always_comb begin
      time_in      = time_ff;
      count_in     = count_ff;
      tag_in       = tag_ff;
      ptr_in       = ptr_ff;
      vld_in       = issue;
      idx_in       = idx_ff;
      due_in       = due_ff;
      best_vld_in  = best_vld_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      best_tag_in  = best_tag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.take) begin
         tag_in = req_entry_tag;
      end
      if (cmd.tick) begin
         time_in = time_ff + req_time_value;
      end

      if (cmd.sched) begin
         count_in = count_ff + dtq_pkg::CNT_BITS'(1);
      end else if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.remove) begin
         count_in = count_ff - dtq_pkg::CNT_BITS'(1);
      end

      if (cmd.scan_init) begin
         ptr_in = '0;
      end else if (cmd.shift_init) begin
         ptr_in = best_idx_ff + dtq_pkg::CNT_BITS'(1);
      end else if (issue) begin
         ptr_in = ptr_ff + dtq_pkg::CNT_BITS'(1);
      end
      if (issue) begin
         idx_in = ptr_ff;
      end

      if (cmd.scan_init) begin
         due_in      = '0;
         best_vld_in = 1'b0;
      end else if (cmd.scan_step && vld_ff) begin
         if (due) begin
            due_in = due_ff + dtq_pkg::CNT_BITS'(1);
         end
         if (better) begin
            best_vld_in = 1'b1;
            best_key_in = key;
            best_idx_in = idx_ff;
            best_tag_in = rd_tag;
         end
      end

      if (cmd.out_fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dtq_pkg::RESULT_EXPIRED;
         rsp_tag_in   = best_tag_ff;
         rsp_last_in  = (due_ff == dtq_pkg::CNT_BITS'(1));
      end else if (cmd.out_reject) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dtq_pkg::RESULT_REJECTED;
         rsp_tag_in   = tag_ff;
         rsp_last_in  = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         vld_ff       <= 1'b0;
         due_ff       <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_ff      <= time_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         vld_ff       <= vld_in;
         due_ff       <= due_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tag_ff      <= tag_in;
      idx_ff      <= idx_in;
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      best_tag_ff <= best_tag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      stat.full      = (count_ff == dtq_pkg::CNT_BITS'(dtq_pkg::QUEUE_DEPTH));
      stat.walk_done = (ptr_ff >= count_ff) && !vld_ff;
      stat.due_any   = (due_ff != '0);
      stat.out_free  = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_fired_tag   = rsp_tag_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `DTQ_ASSERT_IMP(a_count_range, 1'b1, count_ff <= dtq_pkg::CNT_BITS'(dtq_pkg::QUEUE_DEPTH), "pending count beyond depth")
   `DTQ_ASSERT_IMP(a_sched_room, cmd.sched, !stat.full, "schedule written into full store")
   `DTQ_ASSERT_IMP(a_load_free, cmd.out_fire || cmd.out_reject, out_free, "result register overwritten")
   `DTQ_ASSERT_IMP(a_fire_due, cmd.out_fire, best_vld_ff && (due_ff != '0), "fired with nothing due")
   `DTQ_ASSERT_NXT(a_remove_count, cmd.remove, count_ff < dtq_pkg::CNT_BITS'(dtq_pkg::QUEUE_DEPTH), "remove did not shrink store")

endmodule

`default_nettype wire

FILE: design/dtq_ctrl.sv
// sequencer for schedule, clear, reject, tick scan, fire and shift
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [1:0]  req_func,
   output logic             req_stall,
   output dtq_pkg::cmd_type cmd,
   input  wire dtq_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REJECT,
      ST_SCAN,
      ST_EMIT,
      ST_SHIFT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      accept;

   assign accept = req_valid && !stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.take = 1'b1;
               case (dtq_pkg::func_type'(req_func))
                  dtq_pkg::FUNC_SCHED_ABS, dtq_pkg::FUNC_SCHED_REL: begin
                     if (stat.full) begin
                        state_in = ST_REJECT;
                     end else begin
                        cmd.sched = 1'b1;
                        cmd.rel   = (dtq_pkg::func_type'(req_func) == dtq_pkg::FUNC_SCHED_REL);
                     end
                  end
                  dtq_pkg::FUNC_TICK: begin
                     cmd.tick      = 1'b1;
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  dtq_pkg::FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                     cmd.clear = 1'b0;
                  end
               endcase
            end
         end
         ST_REJECT: begin
            if (stat.out_free) begin
               cmd.out_reject = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.walk_done) begin
               state_in = stat.due_any ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_fire   = 1'b1;
               cmd.shift_init = 1'b1;
               state_in       = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (stat.walk_done) begin
               cmd.remove    = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

FILE: design/deadline_timer_queue.sv
// Deadline timer queue: keeps a running time and up to 16 pending timers
// (deadline and tag) in a single-port-read ram. Clear beats and schedules
// into a store with room do not stall the request port. A tick beat
// advances the time, then walks the store (one entry per cycle through the
// ram read port) to find the earliest due timer; each fired timer is loaded
// into the result register once that register is free, then the later
// entries are shifted down, followed by a fresh pass. Results come
// earliest deadline first, ties in insertion order, with last_of_run on the
// final one. A schedule into a full store returns one reject beat. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_func,
   input  wire logic [dtq_pkg::TAG_BITS-1:0]  req_entry_tag,
   input  wire logic [dtq_pkg::TIME_BITS-1:0] req_time_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic [dtq_pkg::TAG_BITS-1:0]       rsp_fired_tag,
   output logic                               rsp_last_of_run
);

   dtq_pkg::cmd_type  cmd;
   dtq_pkg::stat_type stat;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   dtq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_entry_tag   (req_entry_tag),
      .req_time_value  (req_time_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_fired_tag   (rsp_fired_tag),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: tb/deadline_timer_queue_checker.sv
`timescale 1ns / 1ps
// deadline timer queue checker: shadow timer store, predicted fire order and beat comparison
module deadline_timer_queue_checker
   import dtq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [TAG_BITS-1:0]  req_entry_tag,
   input  logic [TIME_BITS-1:0] req_time_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_result_kind,
   input  logic [TAG_BITS-1:0]  rsp_fired_tag,
   input  logic                 rsp_last_of_run,
   output int                   fail_count,
   output int                   outstanding
);

   typedef struct packed {
      logic                kind;
      logic [TAG_BITS-1:0] tag;
      logic                last;
   } timer_result_t;

   logic [TIME_BITS-1:0] now_time;
   logic [TIME_BITS-1:0] store_deadline [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  store_tag [QUEUE_DEPTH];
   int                   store_count;
   timer_result_t        awaited_fires [$];
   timer_result_t        want;
   int                   errors = 0;

   task automatic apply_timer_beat(input func_type func, input logic [TAG_BITS-1:0] tag,
                                   input logic [TIME_BITS-1:0] tv);
      logic [TAG_BITS-1:0]         due_tags [QUEUE_DEPTH];
      int                          fired;
      int                          best;
      logic signed [TIME_BITS-1:0] best_delta;
      logic signed [TIME_BITS-1:0] delta;
      logic                        scanning;
      fired = 0;
      case (func)
         FUNC_SCHED_ABS, FUNC_SCHED_REL: begin
            if (store_count >= QUEUE_DEPTH) begin
               awaited_fires.push_back('{RESULT_REJECTED, tag, 1'b1});
            end else begin
               store_deadline[store_count] = (func == FUNC_SCHED_ABS) ? tv : now_time + tv;
               store_tag[store_count] = tag;
               store_count++;
            end
         end
         FUNC_CLEAR: begin
            store_count = 0;
         end
         default: begin
            now_time = now_time + tv;
            scanning = 1'b1;
            while (scanning && store_count > 0) begin
               // earliest signed delta, first inserted wins ties
               best = 0;
               best_delta = store_deadline[0] - now_time;
               for (int i = 1; i < store_count; i++) begin
                  delta = store_deadline[i] - now_time;
                  if (delta < best_delta) begin
                     best_delta = delta;
                     best = i;
                  end
               end
               if (best_delta > 0) begin
                  scanning = 1'b0;
               end else begin
                  due_tags[fired] = store_tag[best];
                  fired++;
                  for (int i = best; i < store_count - 1; i++) begin
                     store_deadline[i] = store_deadline[i+1];
                     store_tag[i] = store_tag[i+1];
                  end
                  store_count--;
               end
            end
            for (int i = 0; i < fired; i++) begin
               awaited_fires.push_back('{RESULT_EXPIRED, due_tags[i], i == fired - 1});
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         now_time = '0;
         store_count = 0;
         awaited_fires.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_fires.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result beat: kind %0d tag %0d last %0d",
                           rsp_result_kind, rsp_fired_tag, rsp_last_of_run);
               end
            end else begin
               want = awaited_fires.pop_front();
               if (want.kind !== rsp_result_kind || want.tag !== rsp_fired_tag ||
                   want.last !== rsp_last_of_run) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("result mismatch: expected kind %0d tag %0d last %0d, got kind %0d tag %0d last %0d",
                              want.kind, want.tag, want.last,
                              rsp_result_kind, rsp_fired_tag, rsp_last_of_run);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_timer_beat(func_type'(req_func), req_entry_tag, req_time_value);
         end
      end
      fail_count <= errors;
      outstanding <= awaited_fires.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, timer request stimulus, idle control and verdict
module testbench;
   import dtq_pkg::*;

   localparam int RANDOM_ITEMS = 470;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 64;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_func;
   logic [TAG_BITS-1:0]  req_entry_tag;
   logic [TIME_BITS-1:0] req_time_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_result_kind;
   logic [TAG_BITS-1:0]  rsp_fired_tag;
   logic                 rsp_last_of_run;
   int                   fail_count;
   int                   outstanding;

   int                   gap_pct = 16;
   int                   stall_pct = 48;
   int                   idle_cycles;
   logic [TIME_BITS-1:0] stim_now;

   deadline_timer_queue DUT (.*);

   deadline_timer_queue_checker timer_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [TIME_BITS-1:0] rand_time();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[TIME_BITS-1:0];
   endfunction

   task automatic send(input func_type func, input logic [TAG_BITS-1:0] tag,
                       input logic [TIME_BITS-1:0] tv);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_entry_tag <= tag;
      req_time_value <= tv;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (func == FUNC_TICK) begin
         stim_now = stim_now + tv;
      end
   endtask

   initial begin
      int                   sent;
      int                   pick;
      int                   offset;
      logic [TIME_BITS-1:0] tv;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_CLEAR;
      req_entry_tag = '0;
      req_time_value = '0;
      stim_now = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // time wrap on idle ticks, then due and not-due edges of the signed delta
      send(FUNC_TICK, 8'h00, 48'hFFFF_FFFF_FFFF);
      send(FUNC_TICK, 8'hFF, 48'h1);
      send(FUNC_SCHED_ABS, 8'h00, 48'h0);
      send(FUNC_SCHED_ABS, 8'hFF, 48'hFFFF_FFFF_FFFF);
      send(FUNC_SCHED_REL, 8'h5A, 48'h7FFF_FFFF_FFFF);
      send(FUNC_SCHED_REL, 8'hA5, 48'h8000_0000_0000);
      send(FUNC_TICK, 8'h3C, 48'h0);
      send(FUNC_CLEAR, 8'hC3, rand_time());
      send(FUNC_TICK, 8'h00, 48'h7FFF_FFFF_FFFF);
      // full store of equal deadlines, rejects, then one tick fires all
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (i % 2 == 1) begin
            send(FUNC_SCHED_ABS, 8'($urandom_range(255)), stim_now + 48'd3);
         end else begin
            send(FUNC_SCHED_REL, 8'($urandom_range(255)), 48'd3);
         end
      end
      send(FUNC_SCHED_REL, 8'($urandom_range(255)), rand_time());
      send(FUNC_SCHED_ABS, 8'($urandom_range(255)), rand_time());
      send(FUNC_TICK, 8'($urandom_range(255)), 48'd3);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 2 * RANDOM_ITEMS / 3) begin
            gap_pct = 0;
            stall_pct = 0;
         end else if (sent >= RANDOM_ITEMS / 3) begin
            gap_pct = 48;
            stall_pct = 16;
         end
         pick = $urandom_range(99);
         if ($urandom_range(49) == 0) begin
            // burst that fills or overflows the store, then a tick that fires the entries due by then
            repeat ($urandom_range(16, 19)) begin
               send(FUNC_SCHED_REL, 8'($urandom_range(255)), 48'($urandom_range(40)));
               sent++;
            end
            send(FUNC_TICK, 8'($urandom_range(255)), 48'($urandom_range(20, 60)));
            sent++;
         end else if (pick < 48) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
               send(FUNC_SCHED_REL, 8'($urandom_range(255)), 48'($urandom_range(300)));
            end else if (pick < 9) begin
               offset = $urandom_range(340) - 40;
               send(FUNC_SCHED_ABS, 8'($urandom_range(255)), stim_now + 48'(offset));
            end else begin
               send(func_type'($urandom_range(1)), 8'($urandom_range(255)), rand_time());
            end
            sent++;
         end else if (pick < 88) begin
            tv = ($urandom_range(11) == 0) ? rand_time() : 48'($urandom_range(120));
            send(FUNC_TICK, 8'($urandom_range(255)), tv);
            sent++;
         end else if (pick < 92) begin
            send(FUNC_CLEAR, 8'($urandom_range(255)), rand_time());
            sent++;
         end else begin
            send(func_type'($urandom_range(3)), 8'($urandom_range(255)), rand_time());
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
